>>> rtl/trimmed_mean_light_filter_core_defines.svh
// Assertion macros shared by the trimmed-mean light filter RTL.
`ifndef TRIMMED_MEAN_LIGHT_FILTER_CORE_DEFINES_SVH
`define TRIMMED_MEAN_LIGHT_FILTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define TMLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define TMLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMLF_ASSERT(lbl, prop, msg)
`define TMLF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/tmlf_pkg.sv
// Types, constants and helpers of the trimmed-mean light filter.
`default_nettype none

package tmlf_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int WINDOW_DEPTH = 16;

  localparam int SENSOR_W    = 3;
  localparam int READ_W      = 16;
  localparam int VALUE_W     = 17;
  localparam int DEPTH_W     = $clog2(WINDOW_DEPTH);
  localparam int FILL_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W       = READ_W + DEPTH_W;
  localparam int DIV_CNT_W   = $clog2(SUM_W);
  localparam int STORE_DEPTH = SENSOR_COUNT * WINDOW_DEPTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int MIN_AVG     = 4;
  localparam int TRIM_COUNT  = 2;
  localparam int MIN_STEP    = 2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_AVERAGING_ON   = 2'd0,
    REG_WINDOW_SAMPLES = 2'd1,
    REG_ROUNDING_ON    = 2'd2,
    REG_ROUNDING_STEP  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_WALK,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_ROUND,
    ST_ROUND_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_index;
    logic [READ_W-1:0]   reading;
    logic                reading_valid;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] filtered_value;
    logic               value_valid;
  } out_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  quot;
    logic [READ_W-1:0] rem;
  } div_res_t;

  // Circular pointer add within one window.
  function automatic logic [DEPTH_W-1:0] ptr_add(input logic [DEPTH_W-1:0] a,
                                                 input logic [DEPTH_W-1:0] b);
    logic [DEPTH_W:0] s;
    s = (DEPTH_W + 1)'(a) + (DEPTH_W + 1)'(b);
    if (s >= (DEPTH_W + 1)'(WINDOW_DEPTH)) begin
      s = s - (DEPTH_W + 1)'(WINDOW_DEPTH);
    end
    return s[DEPTH_W-1:0];
  endfunction

  function automatic logic [DEPTH_W-1:0] ptr_inc(input logic [DEPTH_W-1:0] a);
    return ptr_add(a, DEPTH_W'(1));
  endfunction

  function automatic logic [STORE_AW-1:0] store_addr(input logic [SENSOR_W-1:0] s,
                                                     input logic [DEPTH_W-1:0] p);
    return STORE_AW'(s) * STORE_AW'(WINDOW_DEPTH) + STORE_AW'(p);
  endfunction

endpackage

`default_nettype wire

>>> rtl/tmlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/tmlf_div.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none

module tmlf_div import tmlf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [READ_W-1:0] divisor,
  output div_res_t               res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     quo;
  logic [SUM_W-1:0]     quo_next;
  logic [READ_W-1:0]    rem;
  logic [READ_W-1:0]    rem_next;
  logic [READ_W-1:0]    dvs;
  logic [READ_W:0]      trial;

  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = READ_W'(trial - {1'b0, dvs});
      quo_next = {quo[SUM_W-2:0], 1'b1};
    end else begin
      rem_next = trial[READ_W-1:0];
      quo_next = {quo[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign res = '{done: done, quot: quo, rem: rem};

endmodule

`default_nettype wire

>>> rtl/trimmed_mean_light_filter_core.sv
// Top level of the trimmed-mean light filter: sequencer, windows and registers.
//
//   channel   dir   handshake              payload
//   in        in    in_valid / in_ready    in_data  (in_t)
//   out       out   out_valid / out_ready  out_data (out_t)
//   cfg       in    APB psel/penable       paddr, pwdata, prdata
//
// An averaged reading takes the window walk over its stored readings and a pass of
// the shared 20-step divider, plus a second pass when rounding is on. A pass-through
// reading (averaging off, or its window still short) skips the walk and the mean but
// takes the rounding pass when rounding is on; a missing reading goes to the output.
// Synchronous reset empties every window; the window store needs no clearing.
// A stalled output holds in its register while the next item is worked on.
`default_nettype none
`include "trimmed_mean_light_filter_core_defines.svh"

module trimmed_mean_light_filter_core import tmlf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // Configuration registers
  logic              averaging_on;
  logic [3:0]        window_samples;
  logic              rounding_on;
  logic [READ_W-1:0] rounding_step;

  state_t state;
  state_t state_next;

  // Per-sensor window bookkeeping
  logic [FILL_W-1:0]  fill [SENSOR_COUNT];
  logic [DEPTH_W-1:0] head [SENSOR_COUNT];

  // Item registers
  logic [SENSOR_W-1:0] sens_r;
  logic [READ_W-1:0]   val_r;
  logic                vld_r;
  logic [VALUE_W-1:0]  res;
  logic [FILL_W-1:0]   cnt;

  // Walk registers
  logic [FILL_W-1:0]  rd_idx;
  logic [DEPTH_W-1:0] rd_ptr;
  logic               pend;
  logic               first;
  logic [SUM_W-1:0]   sum;
  logic [READ_W-1:0]  lo;
  logic [READ_W-1:0]  hi;

  logic                in_go;
  logic                out_load;
  logic                windowed;
  logic                rnd_en;
  logic                issue;
  logic                walk_done;
  logic                mean_done;

  // Append path
  logic [FILL_W-1:0]  f0;
  logic [FILL_W-1:0]  f1;
  logic [FILL_W-1:0]  f2;
  logic [FILL_W-1:0]  f3;
  logic [DEPTH_W-1:0] h0;
  logic [DEPTH_W-1:0] h1;
  logic [DEPTH_W-1:0] h3;
  logic               full;
  logic               short_win;
  logic               trim;

  // Memory and divider hookup
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [STORE_AW-1:0] ram_raddr;
  logic [READ_W-1:0]   ram_rdata;
  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [READ_W-1:0]   div_divisor;
  div_res_t            div_res;
  logic [VALUE_W:0]    rnd_sum;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      averaging_on   <= 1'b0;
      window_samples <= 4'd8;
      rounding_on    <= 1'b0;
      rounding_step  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_AVERAGING_ON:   averaging_on   <= pwdata[0];
        REG_WINDOW_SAMPLES: window_samples <= pwdata[3:0];
        REG_ROUNDING_ON:    rounding_on    <= pwdata[0];
        REG_ROUNDING_STEP:  rounding_step  <= pwdata[READ_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_AVERAGING_ON:   prdata = DATA_W'(averaging_on);
      REG_WINDOW_SAMPLES: prdata = DATA_W'(window_samples);
      REG_ROUNDING_ON:    prdata = DATA_W'(rounding_on);
      REG_ROUNDING_STEP:  prdata = DATA_W'(rounding_step);
    endcase
  end

  // ---------------------------------------------------------------- shared units
  tmlf_ram #(
    .WIDTH (READ_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmlf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  // ---------------------------------------------------------------- datapath comb
  assign windowed  = averaging_on && (32'(in_data.sensor_index) < SENSOR_COUNT);
  assign rnd_en    = rounding_on && (32'(rounding_step) >= MIN_STEP);
  assign in_go     = in_valid && in_ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);
  assign issue     = rd_idx < cnt;
  assign walk_done = !issue && !pend;
  assign mean_done = div_res.done && (state == ST_MEAN_WAIT);

  always_comb begin
    f0        = fill[sens_r];
    h0        = head[sens_r];
    full      = f0 >= FILL_W'(WINDOW_DEPTH);
    h1        = full ? ptr_inc(h0) : h0;
    f1        = full ? f0 - FILL_W'(1) : f0;
    f2        = f1 + FILL_W'(1);
    short_win = f2 < FILL_W'(MIN_AVG);
    trim      = !short_win && (32'(f2) > 32'(window_samples));
    h3        = trim ? ptr_inc(h1) : h1;
    f3        = trim ? f2 - FILL_W'(1) : f2;
  end

  assign ram_waddr = store_addr(sens_r, ptr_add(h1, f1[DEPTH_W-1:0]));
  assign ram_raddr = store_addr(sens_r, rd_ptr);

  always_comb begin
    if (state == ST_MEAN_GO) begin
      div_dividend = sum - SUM_W'(lo) - SUM_W'(hi);
      div_divisor  = READ_W'(cnt - FILL_W'(TRIM_COUNT));
    end else begin
      div_dividend = SUM_W'(res);
      div_divisor  = rounding_step;
    end
  end

  // Snap: value minus remainder, plus one step when the remainder reaches half.
  assign rnd_sum = (VALUE_W + 1)'(res) - (VALUE_W + 1)'(div_res.rem)
                 + ((div_res.rem >= (rounding_step >> 1)) ? (VALUE_W + 1)'(rounding_step)
                                                          : '0);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_go) begin
          if (!in_data.reading_valid) begin
            state_next = ST_DONE;
          end else if (windowed) begin
            state_next = ST_APPEND;
          end else begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_APPEND:     state_next = short_win ? ST_ROUND : ST_WALK;
      ST_WALK:       state_next = walk_done ? ST_MEAN_GO : ST_WALK;
      ST_MEAN_GO:    state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT:  state_next = mean_done ? ST_ROUND : ST_MEAN_WAIT;
      ST_ROUND:      state_next = rnd_en ? ST_ROUND_WAIT : ST_DONE;
      ST_ROUND_WAIT: state_next = div_res.done ? ST_DONE : ST_ROUND_WAIT;
      ST_DONE:       state_next = out_load ? ST_IDLE : ST_DONE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE:    in_ready  = 1'b1;
      ST_APPEND:  ram_we    = 1'b1;
      ST_MEAN_GO: div_start = 1'b1;
      ST_ROUND:   div_start = rnd_en;
      ST_WALK, ST_MEAN_WAIT, ST_ROUND_WAIT, ST_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        fill[i] <= '0;
        head[i] <= '0;
      end
    end else if (in_go && !in_data.reading_valid && windowed) begin
      fill[in_data.sensor_index] <= '0;
    end else if (state == ST_APPEND) begin
      fill[sens_r] <= f3;
      head[sens_r] <= h3;
    end
  end

  // Item, walk and result payload
  always_ff @(posedge clk) begin
    pend <= (state == ST_WALK) && issue;
    unique case (state)
      ST_IDLE: begin
        if (in_go) begin
          sens_r <= in_data.sensor_index;
          val_r  <= in_data.reading;
          vld_r  <= in_data.reading_valid;
          res    <= in_data.reading_valid ? VALUE_W'(in_data.reading) : '0;
        end
      end
      ST_APPEND: begin
        cnt    <= f3;
        rd_idx <= '0;
        rd_ptr <= h3;
        first  <= 1'b1;
        sum    <= '0;
        hi     <= '0;
        lo     <= '0;
      end
      ST_WALK: begin
        if (issue) begin
          rd_idx <= rd_idx + FILL_W'(1);
          rd_ptr <= ptr_inc(rd_ptr);
        end
        if (pend) begin
          sum   <= sum + SUM_W'(ram_rdata);
          first <= 1'b0;
          if (ram_rdata > hi) begin
            hi <= ram_rdata;
          end
          if (first || ram_rdata < lo) begin
            lo <= ram_rdata;
          end
        end
      end
      ST_MEAN_WAIT: begin
        if (div_res.done) begin
          res <= div_res.quot[VALUE_W-1:0];
        end
      end
      ST_ROUND_WAIT: begin
        if (div_res.done) begin
          res <= rnd_sum[VALUE_W-1:0];
        end
      end
      ST_MEAN_GO, ST_ROUND, ST_DONE: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.filtered_value <= res;
      out_data.value_valid    <= vld_r;
    end
  end

  // ---------------------------------------------------------------- assertions
  `TMLF_ASSERT(a_busy_after_accept, in_go |=> !in_ready, "ready after a transaction")
  `TMLF_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !out_valid), "busy after reset")
  `TMLF_ASSERT(a_mean_fits, mean_done |-> (div_res.quot[SUM_W-1:READ_W] == '0), "mean too wide")
  `TMLF_ASSERT(a_fill_bound, (state == ST_APPEND) |-> (f0 <= FILL_W'(WINDOW_DEPTH)), "fill overrun")

endmodule

`default_nettype wire
